// File: rtl/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg: ranging frame parser package
// Item types, frame constants and register map shared by the parser and checker.
// ----------------------------------------------------------------------------
package rfp_pkg;

  localparam int unsigned ADDR_W      = 2;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DIST_W      = 13;
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned TIMEOUT_W   = 16;
  localparam int unsigned ELAPSED_W   = 17;
  localparam int unsigned COUNT_W     = 4;

  localparam logic [7:0]           HEAD_BYTE     = 8'hF0;
  localparam logic [7:0]           LEN_BYTE      = 8'h06;
  localparam logic [7:0]           TAIL_BYTE     = 8'hAA;
  localparam logic [15:0]          MAX_DIST_CM   = 16'd5000;
  localparam logic [COUNT_W-1:0]   LAST_STORED   = 4'd9;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;

  localparam logic [ADDR_W-1:0] REG_TIMEOUT = 2'd0;

  // byte positions inside the frame
  localparam logic [COUNT_W-1:0] POS_HEAD     = 4'd0;
  localparam logic [COUNT_W-1:0] POS_LEN      = 4'd1;
  localparam logic [COUNT_W-1:0] POS_DIST_LO  = 4'd4;
  localparam logic [COUNT_W-1:0] POS_DIST_HI  = 4'd5;
  localparam logic [COUNT_W-1:0] POS_ANGLE_LO = 4'd6;
  localparam logic [COUNT_W-1:0] POS_ANGLE_HI = 4'd7;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_NONE     = 2'd0,
    STATUS_ACCEPTED = 2'd1,
    STATUS_REJECTED = 2'd2
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic                      reading_valid;
    logic [DIST_W-1:0]         distance_cm;
    logic signed [ANGLE_W-1:0] bearing_deg;
    status_t                   frame_status;
  } result_t;

endpackage

// File: rtl/ranging_frame_parser.sv
// ----------------------------------------------------------------------------
// ranging_frame_parser: ten-byte ranging frame parser
// Collects serial bytes into frames, holds the last good distance and angle,
// and ages the reading out on millisecond ticks.
// ----------------------------------------------------------------------------
// the result of an accepted item appears in the output register in the next cycle
// throughput: one item per cycle while no result is stalled; the parser state updates in the accept cycle
// an item is taken while a waiting result is being taken in the same cycle
// reset (synchronous, rst high): no frame in progress, no reading, elapsed zero,
// timeout_ms back to 500, output register empty
module ranging_frame_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  rfp_pkg::item_t               item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output rfp_pkg::result_t             result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rfp_pkg::ADDR_W-1:0]   paddr,
  input  logic [rfp_pkg::DATA_W-1:0]   pwdata,
  output logic [rfp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import rfp_pkg::*;

  logic                      take;
  logic [COUNT_W-1:0]        byte_count, byte_count_next;
  logic [7:0]                head_byte, len_byte;
  logic [7:0]                dist_lo, dist_hi, angle_lo, angle_hi;
  logic [DIST_W-1:0]         held_distance, held_distance_next;
  logic [ANGLE_W-1:0]        held_angle, held_angle_next;
  logic                      valid_flag, valid_flag_next;
  logic [ELAPSED_W-1:0]      elapsed_ms, elapsed_ms_next, elapsed_inc;
  logic [TIMEOUT_W-1:0]      timeout_ms;
  logic [15:0]               frame_dist;
  logic                      frame_good;
  status_t                   status_next;

  assign take       = item_valid && !item_stall;
  assign item_stall = result_valid && result_stall;
  assign pready     = 1'b1;
  assign prdata     = (paddr == REG_TIMEOUT) ? {{(DATA_W-TIMEOUT_W){1'b0}}, timeout_ms} : '0;

  assign frame_dist = {dist_hi, dist_lo};
  assign frame_good = (head_byte == HEAD_BYTE) && (len_byte == LEN_BYTE) &&
                      (item.rx_byte == TAIL_BYTE) && (frame_dist != 16'd0) &&
                      (frame_dist <= MAX_DIST_CM);
  assign elapsed_inc = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 1'b1;

  always_comb begin
    byte_count_next    = byte_count;
    held_distance_next = held_distance;
    held_angle_next    = held_angle;
    valid_flag_next    = valid_flag;
    elapsed_ms_next    = elapsed_ms;
    status_next        = STATUS_NONE;
    unique case (item.op)
      OP_TICK: begin
        elapsed_ms_next = elapsed_inc;
        if (valid_flag && (elapsed_inc > {1'b0, timeout_ms})) begin
          valid_flag_next = 1'b0;
        end
      end
      OP_BYTE: begin
        priority if (byte_count == POS_HEAD && item.rx_byte != HEAD_BYTE) begin
          byte_count_next = byte_count;
        end else if (byte_count < LAST_STORED) begin
          byte_count_next = byte_count + 1'b1;
        end else begin
          byte_count_next = POS_HEAD;
          if (frame_good) begin
            status_next        = STATUS_ACCEPTED;
            held_distance_next = frame_dist[DIST_W-1:0];
            held_angle_next    = {angle_hi, angle_lo};
            valid_flag_next    = 1'b1;
            elapsed_ms_next    = '0;
          end else begin
            status_next = STATUS_REJECTED;
          end
        end
      end
      default: begin
        status_next = STATUS_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      held_distance <= '0;
      held_angle    <= '0;
      valid_flag    <= 1'b0;
      elapsed_ms    <= '0;
      timeout_ms    <= TIMEOUT_RESET;
      result_valid  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_TIMEOUT) begin
        timeout_ms <= pwdata[TIMEOUT_W-1:0];
      end
      if (take) begin
        byte_count    <= byte_count_next;
        held_distance <= held_distance_next;
        held_angle    <= held_angle_next;
        valid_flag    <= valid_flag_next;
        elapsed_ms    <= elapsed_ms_next;
        result_valid  <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // frame bytes that the check needs
  always_ff @(posedge clk) begin
    if (take && item.op == OP_BYTE && byte_count_next != byte_count &&
        byte_count < LAST_STORED) begin
      unique case (byte_count)
        POS_HEAD:     head_byte <= item.rx_byte;
        POS_LEN:      len_byte  <= item.rx_byte;
        POS_DIST_LO:  dist_lo   <= item.rx_byte;
        POS_DIST_HI:  dist_hi   <= item.rx_byte;
        POS_ANGLE_LO: angle_lo  <= item.rx_byte;
        POS_ANGLE_HI: angle_hi  <= item.rx_byte;
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (take) begin
      result.reading_valid <= valid_flag_next;
      result.distance_cm   <= held_distance_next;
      result.bearing_deg   <= held_angle_next;
      result.frame_status  <= status_next;
    end
  end

endmodule

// File: rtl/rfp_checker.sv
// ----------------------------------------------------------------------------
// rfp_checker: ranging frame parser port checker
// Watches the parser's ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module rfp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_stall,
  input rfp_pkg::item_t               item,
  input logic                         result_valid,
  input logic                         result_stall,
  input rfp_pkg::result_t             result,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [rfp_pkg::ADDR_W-1:0]   paddr,
  input logic [rfp_pkg::DATA_W-1:0]   pwdata,
  input logic [rfp_pkg::DATA_W-1:0]   prdata,
  input logic                         pready
);
  import rfp_pkg::*;

  // a stalled result holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // every accepted item produces a result in the next cycle
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> result_valid)
    else $error("accepted item gave no result");

  // ticks never end a frame
  a_tick_status: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.op == OP_TICK |=> result.frame_status == STATUS_NONE)
    else $error("tick item reported a frame status");

  // an accepted frame leaves a valid in-range reading
  a_accept_reading: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_status == STATUS_ACCEPTED |->
      result.reading_valid && result.distance_cm != '0 &&
      {3'b000, result.distance_cm} <= MAX_DIST_CM)
    else $error("accepted frame without a valid reading");

  // the input side waits only on a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("item stalled with no result waiting");

endmodule

bind ranging_frame_parser rfp_checker u_rfp_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: ranging frame parser testbench
// Drives serial bytes and millisecond ticks with random gaps and output
// stalls, predicts every reading and compares it field by field in order.
// The timeout register is swept between phases, extremes included.
// ----------------------------------------------------------------------------
module tb;
  import rfp_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1500000;

  class reading_tracker;
    logic [7:0]           frame_store [0:LAST_STORED-1];
    logic [COUNT_W-1:0]   byte_count;
    logic [DIST_W-1:0]    distance;
    logic [ANGLE_W-1:0]   angle;
    logic                 valid;
    logic [ELAPSED_W-1:0] elapsed;
    logic [TIMEOUT_W-1:0] timeout;
    result_t              expected_readings [$];
    int                   errors;

    function new();
      byte_count = '0;
      distance   = '0;
      angle      = '0;
      valid      = 1'b0;
      elapsed    = '0;
      timeout    = TIMEOUT_RESET;
      errors     = 0;
    endfunction

    function void note_item(item_t it);
      logic [15:0] frame_cm;
      status_t     status;
      result_t     want;
      status = STATUS_NONE;
      if (it.op == OP_TICK) begin
        if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
        if (valid && elapsed > {1'b0, timeout}) valid = 1'b0;
      end else if (byte_count != '0 || it.rx_byte == HEAD_BYTE) begin
        if (byte_count < LAST_STORED) begin
          frame_store[byte_count] = it.rx_byte;
          byte_count = byte_count + 1'b1;
        end else begin
          // tenth byte is the tail, checked straight from the input
          frame_cm = {frame_store[POS_DIST_HI], frame_store[POS_DIST_LO]};
          if (frame_store[POS_HEAD] != HEAD_BYTE || frame_store[POS_LEN] != LEN_BYTE ||
              it.rx_byte != TAIL_BYTE || frame_cm == 16'd0 || frame_cm > MAX_DIST_CM) begin
            status = STATUS_REJECTED;
          end else begin
            status   = STATUS_ACCEPTED;
            distance = frame_cm[DIST_W-1:0];
            angle    = {frame_store[POS_ANGLE_HI], frame_store[POS_ANGLE_LO]};
            valid    = 1'b1;
            elapsed  = '0;
          end
          byte_count = '0;
        end
      end
      want.reading_valid = valid;
      want.distance_cm   = distance;
      want.bearing_deg   = angle;
      want.frame_status  = status;
      expected_readings.push_back(want);
    endfunction

    function void check_reading(result_t got);
      result_t want;
      if (expected_readings.size() == 0) begin
        $display("%0t tb: reading with none expected, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      if (got.reading_valid !== want.reading_valid) begin
        $display("%0t tb: reading_valid expected %0b got %0b", $time,
                 want.reading_valid, got.reading_valid);
        errors++;
      end
      if (got.distance_cm !== want.distance_cm) begin
        $display("%0t tb: distance_cm expected %0d got %0d", $time,
                 want.distance_cm, got.distance_cm);
        errors++;
      end
      if (got.bearing_deg !== want.bearing_deg) begin
        $display("%0t tb: bearing_deg expected %0d got %0d", $time,
                 $signed(want.bearing_deg), $signed(got.bearing_deg));
        errors++;
      end
      if (got.frame_status !== want.frame_status) begin
        $display("%0t tb: frame_status expected %0d got %0d", $time,
                 want.frame_status, got.frame_status);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_stall;
  item_t               item         = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  result_t             result;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [DATA_W-1:0]   pwdata       = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  reading_tracker tracker;
  bit             calm = 1'b0;
  int             tick_pct = 0;
  int             items_sent = 0;
  int             stall_left = 0;

  ranging_frame_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb: done, errors");
    $finish;
  end

  // readings are checked before the item of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) tracker.check_reading(result);
      if (item_valid && !item_stall) tracker.note_item(item);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 10) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic send_item(input item_t it);
    if (!calm && $urandom_range(0, 99) < 15) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    item_t it;
    it.op = OP_BYTE;
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic send_tick();
    item_t it;
    it.op = OP_TICK;
    it.rx_byte = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [15:0] range_cm,
                            input logic [15:0] ang, input logic [7:0] tail);
    logic [7:0] frame [0:9];
    frame[0] = HEAD_BYTE;
    frame[1] = len;
    frame[2] = 8'($urandom);
    frame[3] = 8'($urandom);
    frame[4] = range_cm[7:0];
    frame[5] = range_cm[15:8];
    frame[6] = ang[7:0];
    frame[7] = ang[15:8];
    frame[8] = 8'($urandom);
    frame[9] = tail;
    for (int i = 0; i < 10; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_tick();
      send_byte(frame[i]);
    end
  endtask

  task automatic stop_items();
    item_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (tracker.expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [TIMEOUT_W-1:0] value);
    logic [DATA_W-1:0] rd;
    stop_items();
    wait_idle();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_TIMEOUT;
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[TIMEOUT_W-1:0] !== value) begin
      $display("%0t tb: timeout_ms readback expected %0d got %0d", $time,
               value, rd[TIMEOUT_W-1:0]);
      tracker.errors++;
    end
    tracker.timeout = value;
  endtask

  task automatic random_frame();
    logic [7:0]  len;
    logic [7:0]  tail;
    logic [15:0] range_cm;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      range_cm = 16'($urandom_range(1, 5000));
    end else if (pick < 85) begin
      case ($urandom_range(0, 3))
        0: range_cm = 16'd0;
        1: range_cm = 16'd1;
        2: range_cm = MAX_DIST_CM;
        default: range_cm = MAX_DIST_CM + 16'd1;
      endcase
    end else begin
      range_cm = 16'($urandom);
    end
    len  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : LEN_BYTE;
    tail = ($urandom_range(0, 9) == 0) ? 8'($urandom) : TAIL_BYTE;
    send_frame(len, range_cm, 16'($urandom), tail);
  endtask

  task automatic run_phase(input logic [TIMEOUT_W-1:0] value, input int count,
                           input int pct);
    int start;
    int keep;
    set_timeout(value);
    tick_pct = pct;
    start = items_sent;
    while (items_sent - start < count) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          repeat ($urandom_range(1, 30)) send_tick();
        end
        3, 4: begin
          // noise, may open a frame that swallows what follows
          keep = items_sent;
          repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
          items_sent = keep;
        end
        default: random_frame();
      endcase
    end
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before any frame, then dropped openers
    send_tick();
    send_tick();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0F);
    // distance and angle extremes, then each reject reason
    send_frame(LEN_BYTE, 16'd1, 16'h7FFF, TAIL_BYTE);
    send_frame(LEN_BYTE, MAX_DIST_CM, 16'h8000, TAIL_BYTE);
    send_frame(LEN_BYTE, MAX_DIST_CM + 16'd1, 16'h1234, TAIL_BYTE);
    send_frame(LEN_BYTE, 16'd0, 16'h1234, TAIL_BYTE);
    send_frame(8'h07, 16'd100, 16'h1234, TAIL_BYTE);
    send_frame(LEN_BYTE, 16'd100, 16'h1234, 8'h55);

    // zero timeout expires on the first tick
    set_timeout(16'd0);
    send_frame(LEN_BYTE, 16'd250, 16'hFF9C, TAIL_BYTE);
    send_tick();
    set_timeout(16'd3);
    send_frame(LEN_BYTE, 16'd42, 16'd90, TAIL_BYTE);
    repeat (4) send_tick();
    // a lowered timeout applies at the next tick
    set_timeout(TIMEOUT_RESET);
    send_frame(LEN_BYTE, 16'd777, 16'd5, TAIL_BYTE);
    repeat (10) send_tick();
    set_timeout(16'd5);
    send_tick();

    // widest timeout keeps the reading through a run of ticks
    set_timeout(16'hFFFF);
    send_frame(LEN_BYTE, 16'd3000, 16'hC000, TAIL_BYTE);
    repeat (40) send_tick();
    send_frame(LEN_BYTE, 16'd12, 16'd33, TAIL_BYTE);
    send_tick();

    run_phase(16'd0, 330, 25);
    run_phase(16'($urandom_range(1, 40)), 330, 30);
    run_phase(16'hFFFF, 330, 15);
    calm = 1'b1;
    run_phase(16'($urandom_range(1, 12)), 330, 30);

    stop_items();
    wait_idle();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rfp_pkg.sv
rtl/ranging_frame_parser.sv
rtl/rfp_checker.sv
tb/tb.sv
